>>> rtl/srsc_pkg.sv
// ----------------------------------------------------------------------------
// srsc_pkg
// Shared types and constants for the shadow return stack checker.
// ----------------------------------------------------------------------------
package srsc_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int ADDR_W          = 64;
    localparam int CNT_W           = 32;
    localparam int LEVEL_W         = 7;
    localparam int STATUS_W        = 2;
    localparam int APB_AW          = 2;
    localparam int APB_DW          = 32;

    localparam logic [APB_AW-1:0] REG_ENABLE_ADDR = '0;

    localparam logic FUNC_CALL = 1'b0;
    localparam logic FUNC_RET  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_MISMATCH  = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // what an accepted word does to the stack
    typedef enum logic [2:0] {
        K_BYPASS,
        K_PUSH,
        K_FULL,
        K_EMPTY,
        K_POP
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [ADDR_W-1:0]   address;
        logic [LEVEL_W-1:0]  level;
    } req_t;

endpackage

>>> rtl/srsc_ram.sv
// ----------------------------------------------------------------------------
// srsc_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module srsc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/srsc_check.sv
// ----------------------------------------------------------------------------
// srsc_check
// Compare stage and output register: checks the popped entry against the
// return target, keeps the saturating bad return count, holds the result word.
// ----------------------------------------------------------------------------
module srsc_check (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              req_valid,
    input  srsc_pkg::req_t                    req,
    output logic                              req_ready,
    input  logic [srsc_pkg::ADDR_W-1:0]       rdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output srsc_pkg::status_t                 m_status,
    output logic [srsc_pkg::ADDR_W-1:0]       m_expected,
    output logic [srsc_pkg::CNT_W-1:0]        m_total,
    output logic [srsc_pkg::LEVEL_W-1:0]      m_level
);

    logic                          s1_valid_reg, s1_valid_next;
    srsc_pkg::req_t                s1_req_reg;
    logic                          out_valid_reg, out_valid_next;
    srsc_pkg::status_t             status_reg, status_next;
    logic [srsc_pkg::ADDR_W-1:0]   expected_reg, expected_next;
    logic [srsc_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [srsc_pkg::LEVEL_W-1:0]  level_reg;
    logic                          s1_adv;
    logic                          bad;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || m_tready);
    assign req_ready = !s1_valid_reg || s1_adv;

    always_comb begin
        status_next   = srsc_pkg::ST_OK;
        expected_next = '0;
        bad           = 1'b0;
        case (s1_req_reg.kind)
            srsc_pkg::K_FULL: begin
                status_next = srsc_pkg::ST_FULL;
            end
            srsc_pkg::K_EMPTY: begin
                status_next = srsc_pkg::ST_UNDERFLOW;
                bad         = 1'b1;
            end
            srsc_pkg::K_POP: begin
                expected_next = rdata;
                if (rdata != s1_req_reg.address) begin
                    status_next = srsc_pkg::ST_MISMATCH;
                    bad         = 1'b1;
                end
            end
            default: begin
                status_next = srsc_pkg::ST_OK;
            end
        endcase
        cnt_next = (bad && cnt_reg != '1) ? cnt_reg + 1'b1 : cnt_reg;

        s1_valid_next  = req_valid && req_ready ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_adv ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv) begin
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req_valid && req_ready) begin
            s1_req_reg <= req;
        end
        if (s1_adv) begin
            status_reg   <= status_next;
            expected_reg <= expected_next;
            level_reg    <= s1_req_reg.level;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_status   = status_reg;
    assign m_expected = expected_reg;
    assign m_total    = cnt_reg;
    assign m_level    = level_reg;

endmodule

>>> rtl/shadow_return_stack_checker.sv
// ----------------------------------------------------------------------------
// shadow_return_stack_checker
// Shadow return address stack: while enabled, calls push, returns pop and compare.
// ----------------------------------------------------------------------------
// Flow: the accepted word and its RAM read are registered, then the compare result.
// Throughput: one word per cycle when m_tready does not stall; the stack pointer is
//   updated at accept, so the next word sees it at once; stalls hold RAM read data.
// Reset: stack empty, bad return count zero, checking enabled. Stack RAM
//   contents are not cleared; only entries below the pointer are ever read.
// ----------------------------------------------------------------------------
module shadow_return_stack_checker #(
    parameter int STACK_DEPTH = srsc_pkg::STACK_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [srsc_pkg::APB_AW-1:0]   paddr,
    input  logic [srsc_pkg::APB_DW-1:0]   pwdata,
    output logic [srsc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,   // [63:0] address
    input  logic                          s_tuser,   // [0] func
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [103:0]                  m_tdata,   // [63:0] expected_address,
                                                     // [95:64] bad_return_total,
                                                     // [102:96] stack_level, [103] 0
    output logic [1:0]                    m_tuser    // [1:0] status
);

    localparam int PTR_W = $clog2(STACK_DEPTH + 1);
    localparam int AW    = $clog2(STACK_DEPTH);

    logic                          enable_reg;
    logic [PTR_W-1:0]              top_reg, top_next;
    logic [PTR_W-1:0]              top_m1;
    srsc_pkg::kind_t               kind;
    srsc_pkg::req_t                req;
    logic                          req_ready;
    logic                          s_acc;
    logic                          ram_en;
    logic [AW-1:0]                 ram_addr;
    logic [srsc_pkg::ADDR_W-1:0]   rdata;
    srsc_pkg::status_t             m_status;
    logic [srsc_pkg::ADDR_W-1:0]   m_expected;
    logic [srsc_pkg::CNT_W-1:0]    m_total;
    logic [srsc_pkg::LEVEL_W-1:0]  m_level;

    // configuration: single register, enable in bit 0
    assign pready = 1'b1;
    assign prdata = {{(srsc_pkg::APB_DW-1){1'b0}}, enable_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b1;
        end else if (psel && penable && pwrite && paddr == srsc_pkg::REG_ENABLE_ADDR) begin
            enable_reg <= pwdata[0];
        end
    end

    assign s_tready = req_ready;
    assign s_acc    = s_tvalid && req_ready;
    assign top_m1   = top_reg - 1'b1;

    always_comb begin
        if (!enable_reg) begin
            kind = srsc_pkg::K_BYPASS;
        end else if (s_tuser == srsc_pkg::FUNC_CALL) begin
            kind = (top_reg == PTR_W'(STACK_DEPTH)) ? srsc_pkg::K_FULL : srsc_pkg::K_PUSH;
        end else begin
            kind = (top_reg == '0) ? srsc_pkg::K_EMPTY : srsc_pkg::K_POP;
        end

        case (kind)
            srsc_pkg::K_PUSH: top_next = top_reg + 1'b1;
            srsc_pkg::K_POP:  top_next = top_m1;
            default:          top_next = top_reg;
        endcase

        req.kind    = kind;
        req.address = s_tdata;
        req.level   = srsc_pkg::LEVEL_W'(top_next);

        ram_en   = s_acc && (kind == srsc_pkg::K_PUSH || kind == srsc_pkg::K_POP);
        ram_addr = (kind == srsc_pkg::K_PUSH) ? top_reg[AW-1:0] : top_m1[AW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg <= '0;
        end else if (s_acc) begin
            top_reg <= top_next;
        end
    end

    srsc_ram #(
        .WIDTH (srsc_pkg::ADDR_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (kind == srsc_pkg::K_PUSH),
        .addr  (ram_addr),
        .wdata (s_tdata),
        .rdata (rdata)
    );

    srsc_check u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (s_tvalid),
        .req        (req),
        .req_ready  (req_ready),
        .rdata      (rdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_status   (m_status),
        .m_expected (m_expected),
        .m_total    (m_total),
        .m_level    (m_level)
    );

    assign m_tdata = {1'b0, m_level, m_total, m_expected};
    assign m_tuser = m_status;

    a_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        top_reg <= PTR_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_push_inc: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && kind == srsc_pkg::K_PUSH |=> top_reg == PTR_W'($past(top_reg) + 1'b1))
        else $error("push did not advance pointer");

    a_empty_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (kind == srsc_pkg::K_EMPTY || kind == srsc_pkg::K_FULL)
        |=> top_reg == $past(top_reg))
        else $error("pointer moved on rejected word");

endmodule
